FILE: hdl/fac_pkg.sv
// Shared constants, register codes and types for the fire alarm controller.
package fac_pkg;

  // Window depth and sample width of the moving-average temperature check.
  localparam int WINDOW_SAMPLES = 16;
  localparam int SAMPLE_BITS    = 12;
  localparam int WIN_IDX_BITS   = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 0;
  localparam int SUM_BITS       = SAMPLE_BITS + WIN_IDX_BITS;
  // Sum width used for compares against 16-bit values and for saturation.
  localparam int SUM_WIDE       = (SUM_BITS > 17) ? SUM_BITS : 17;

  // Fixed field widths of the ports.
  localparam int ADC_BITS       = 12;
  localparam int IN_DATA_BITS   = 16;
  localparam int OUT_DATA_BITS  = 24;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int MS_BITS        = 16;
  localparam int STEP_BITS      = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_TEMP_LIMIT  = 3'd0,
    REG_TIME_STEP   = 3'd1,
    REG_PERIOD_BOTH = 3'd2,
    REG_PERIOD_GAS  = 3'd3,
    REG_PERIOD_HEAT = 3'd4
  } cfg_reg_t;

  // Blink timing settings handed to the alarm unit.
  typedef struct packed {
    logic [STEP_BITS-1:0] time_step;
    logic [MS_BITS-1:0]   period_both;
    logic [MS_BITS-1:0]   period_gas;
    logic [MS_BITS-1:0]   period_heat;
  } blink_cfg_t;

  // Detection events of one word.
  typedef struct packed {
    logic tick;
    logic deact;
    logic gas_now;
    logic heat_now;
    logic test;
  } alarm_evt_t;

  // Alarm state after one word has been applied.
  typedef struct packed {
    logic siren;
    logic strobe;
    logic alarm;
    logic gas;
    logic heat;
  } alarm_st_t;

endpackage

FILE: hdl/fire_alarm_controller.sv
// Top level of the fire alarm controller with moving-average temperature check.
//
// Input stream: in_tuser selects the word kind (0 tick, 1 deactivate alarm);
// in_tdata carries the ADC sample, the gas pin (low means gas) and the test
// button. Each accepted word yields exactly one result word on the out_
// stream: drive levels, alarm and latch status, the detections of that
// tick and the window sum.
// The result word is registered and shows up on the cycle after the input
// word is accepted. Throughput is one word per cycle while the receiver takes
// results; the sample chain, running sum and blink counter all update in the
// cycle in which a word is accepted.
// When the receiver stalls, the result register holds its word and in_tready
// drops until the word is taken; it stays high while the register drains.
// Reset (rst_n low, synchronous) clears the sample window and running sum,
// clears all latches, sets the siren level high and the strobe low, and loads
// the default limit, time step and blink periods. The user, not the block, must
// write registers via cfg_we/cfg_addr/cfg_wdata only while no word is in flight.
module fire_alarm_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: adc_sample[11:0], gas_pin, test_button, zero fill.
  input  logic [fac_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // Fields from bit 0: action.
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: siren_drive, strobe_drive, alarm_on, gas_latched,
  // heat_latched, gas_now, heat_now, window_sum[15:0], zero fill.
  output logic [fac_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input  logic                              cfg_we,
  input  logic [fac_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [fac_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import fac_pkg::*;

  logic [MS_BITS-1:0]       temp_limit_r;
  blink_cfg_t               bcfg_r;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r;
  logic [OUT_DATA_BITS-1:0] out_data_nxt;

  logic                     accept;
  logic                     tick;
  logic [ADC_BITS-1:0]      adc_sample;
  logic [SAMPLE_BITS-1:0]   sample;
  logic [SUM_BITS-1:0]      sum_nxt;
  logic [SUM_BITS-1:0]      sum_cur;
  logic [SUM_WIDE-1:0]      sum_wide;
  logic [MS_BITS-1:0]       window_sum;
  alarm_evt_t               evt;
  alarm_st_t                st_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_limit_r       <= 16'd9930;
      bcfg_r.time_step   <= 8'd10;
      bcfg_r.period_both <= 16'd100;
      bcfg_r.period_gas  <= 16'd1000;
      bcfg_r.period_heat <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_TEMP_LIMIT:  temp_limit_r       <= cfg_wdata;
        REG_TIME_STEP:   bcfg_r.time_step   <= cfg_wdata[STEP_BITS-1:0];
        REG_PERIOD_BOTH: bcfg_r.period_both <= cfg_wdata;
        REG_PERIOD_GAS:  bcfg_r.period_gas  <= cfg_wdata;
        REG_PERIOD_HEAT: bcfg_r.period_heat <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: take a word whenever the result register is free or draining.
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign tick       = accept && !in_tuser;
  assign adc_sample = in_tdata[ADC_BITS-1:0];
  assign sample     = SAMPLE_BITS'(adc_sample);

  fac_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (tick),
    .sample   (sample),
    .sum_nxt  (sum_nxt),
    .sum_cur  (sum_cur)
  );

  // Over-temperature compare and saturated sum for the result word.
  always_comb begin
    sum_wide   = SUM_WIDE'(sum_nxt);
    window_sum = (sum_wide > SUM_WIDE'(16'hFFFF)) ? 16'hFFFF : sum_wide[MS_BITS-1:0];
    evt.tick     = tick;
    evt.deact    = accept && in_tuser;
    evt.heat_now = tick && (sum_wide > SUM_WIDE'(temp_limit_r));
    evt.gas_now  = tick && !in_tdata[ADC_BITS];
    evt.test     = tick && in_tdata[ADC_BITS+1];
  end

  fac_alarm u_alarm (
    .clk    (clk),
    .rst_n  (rst_n),
    .evt    (evt),
    .bcfg   (bcfg_r),
    .st_nxt (st_nxt)
  );

  // Result register.
  always_comb begin
    out_data_nxt  = {1'b0, window_sum, evt.heat_now, evt.gas_now, st_nxt.heat,
                     st_nxt.gas, st_nxt.alarm, st_nxt.strobe, st_nxt.siren};
    out_valid_nxt = out_valid_r && !out_tready;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A latched gas detection always comes with the alarm on.
  a_gas_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[2])
    else $error("gas latched without alarm");

  // A heat detection on a tick is reflected in the heat latch.
  a_heat_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tdata[4])
    else $error("heat detected but not latched");

  // The running sum moves only on an accepted tick.
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !tick |=> $stable(sum_cur))
    else $error("running sum changed without a tick");

endmodule

FILE: hdl/fac_cell.sv
// One sample cell of the window shift line.
module fac_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           shift_en,
  input  logic [fac_pkg::SAMPLE_BITS-1:0] din,
  output logic [fac_pkg::SAMPLE_BITS-1:0] dout
);
  import fac_pkg::*;

  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] sample_nxt;

  // Take the neighbor's sample on every tick.
  always_comb begin
    sample_nxt = shift_en ? din : sample_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

  assign dout = sample_r;

endmodule

FILE: hdl/fac_ring.sv
// Sample window as a chain of cells with a running sum.
module fac_ring (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            shift_en,
  input  logic [fac_pkg::SAMPLE_BITS-1:0] sample,
  output logic [fac_pkg::SUM_BITS-1:0]    sum_nxt,
  output logic [fac_pkg::SUM_BITS-1:0]    sum_cur
);
  import fac_pkg::*;

  logic [SAMPLE_BITS-1:0] tap [WINDOW_SAMPLES+1];
  logic [SUM_BITS-1:0]    sum_r;

  // The newest sample enters the head; the oldest leaves at the tail.
  assign tap[0] = sample;

  for (genvar i = 0; i < WINDOW_SAMPLES; i++) begin : g_cell
    fac_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .din      (tap[i]),
      .dout     (tap[i+1])
    );
  end

  // Replace the oldest sample in the sum; the true value never underflows.
  always_comb begin
    if (shift_en) begin
      sum_nxt = sum_r - SUM_BITS'(tap[WINDOW_SAMPLES]) + SUM_BITS'(sample);
    end else begin
      sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_cur = sum_r;

endmodule

FILE: hdl/fac_alarm.sv
// Alarm latches and the siren and strobe blink counter.
module fac_alarm (
  input  logic                clk,
  input  logic                rst_n,
  input  fac_pkg::alarm_evt_t evt,
  input  fac_pkg::blink_cfg_t bcfg,
  output fac_pkg::alarm_st_t  st_nxt
);
  import fac_pkg::*;

  alarm_st_t          st_r;
  logic [MS_BITS-1:0] elapsed_r;
  logic [MS_BITS-1:0] elapsed_nxt;
  logic [MS_BITS:0]   elapsed_add;
  logic [MS_BITS-1:0] elapsed_sat;
  logic [MS_BITS-1:0] period;

  // Saturating millisecond count for this tick.
  always_comb begin
    elapsed_add = {1'b0, elapsed_r} + (MS_BITS + 1)'(bcfg.time_step);
    elapsed_sat = elapsed_add[MS_BITS] ? '1 : elapsed_add[MS_BITS-1:0];
  end

  // Latch updates, period selection and drive toggling.
  always_comb begin
    st_nxt      = st_r;
    elapsed_nxt = elapsed_r;
    period      = '0;
    if (evt.deact) begin
      st_nxt.gas   = 1'b0;
      st_nxt.heat  = 1'b0;
      st_nxt.alarm = 1'b0;
    end else if (evt.tick) begin
      if (evt.heat_now || evt.test) begin
        st_nxt.heat  = 1'b1;
        st_nxt.alarm = 1'b1;
      end
      if (evt.gas_now || evt.test) begin
        st_nxt.gas   = 1'b1;
        st_nxt.alarm = 1'b1;
      end
      if (st_nxt.gas && st_nxt.heat) begin
        period = bcfg.period_both;
      end else if (st_nxt.gas) begin
        period = bcfg.period_gas;
      end else if (st_nxt.heat) begin
        period = bcfg.period_heat;
      end
      elapsed_nxt = elapsed_sat;
      if (st_nxt.alarm) begin
        if (elapsed_sat >= period) begin
          elapsed_nxt   = '0;
          st_nxt.siren  = !st_r.siren;
          st_nxt.strobe = !st_r.strobe;
        end
      end else begin
        st_nxt.siren  = 1'b1;
        st_nxt.strobe = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{siren: 1'b1, strobe: 1'b0, alarm: 1'b0, gas: 1'b0, heat: 1'b0};
      elapsed_r <= '0;
    end else begin
      st_r      <= st_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule
